/* rtl/tgp_pkg.sv */
// Shared types, constants and a helper function for the text glyph placement block.
package tgp_pkg;

  // Pen coordinate width and derived widths
  localparam int COORD_BITS  = 16;
  localparam int SCREEN_W    = 16;
  localparam int WIDE_W      = ((COORD_BITS > SCREEN_W) ? COORD_BITS : SCREEN_W) + 2;

  // Tab stops are TAB_SPACES space widths apart
  localparam int TAB_SPACES  = 4;
  localparam int SPACE_W     = 8;
  localparam int TAB_W       = SPACE_W + $clog2(TAB_SPACES);
  localparam int DIV_STEPS   = COORD_BITS;
  localparam int CNT_W       = $clog2(DIV_STEPS);

  localparam logic [SPACE_W-1:0] DEFAULT_SPACE = 8'd8;

  // Control characters
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;

  // Stream payload widths
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [WIDE_W-1:0]     wide_t;

  localparam wide_t COORD_MAX = wide_t'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam wide_t COORD_MIN = -COORD_MAX - wide_t'(1);

  // Register indexes on the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ORIGIN_X      = 3'd0,
    CFG_ORIGIN_Y      = 3'd1,
    CFG_WRAP_WIDTH    = 3'd2,
    CFG_WRAP_ENABLE   = 3'd3,
    CFG_TEXT_COLOR    = 3'd4,
    CFG_LINE_PITCH    = 3'd5,
    CFG_GLYPH_SPACING = 3'd6,
    CFG_SPACE_WIDTH   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [14:0]        wrap_width;
    logic               wrap_enable;
    logic [31:0]        text_color;
    logic [7:0]         line_pitch;
    logic signed [7:0]  glyph_spacing;
    logic [7:0]         space_width;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic place;
    logic div_step;
    logic tab_finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic item_tab;
    logic item_glyph;
    logic div_last;
    logic out_free;
  } sts_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PLACE = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_TAB   = 4'b1000
  } state_e;

  // Clamp a wide signed value to the pen coordinate range
  function automatic coord_t sat_coord(wide_t v);
    coord_t r;
    if (v > COORD_MAX) begin
      r = COORD_MAX[COORD_BITS-1:0];
    end else if (v < COORD_MIN) begin
      r = COORD_MIN[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/tgp_cfg_regs.sv */
// Configuration register file for the text glyph placement block.
module tgp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [tgp_pkg::CFG_ADDR_W-1:0] addr_i,
  input  logic [tgp_pkg::CFG_DATA_W-1:0] data_i,
  output tgp_pkg::cfg_t                  cfg_o
);
  import tgp_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign ready_o = 1'b1;
  assign cfg_o   = cfg_q;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (valid_i) begin
      case (cfg_idx_e'(addr_i))
        CFG_ORIGIN_X:      cfg_d.origin_x      = data_i[15:0];
        CFG_ORIGIN_Y:      cfg_d.origin_y      = data_i[15:0];
        CFG_WRAP_WIDTH:    cfg_d.wrap_width    = data_i[14:0];
        CFG_WRAP_ENABLE:   cfg_d.wrap_enable   = data_i[0];
        CFG_TEXT_COLOR:    cfg_d.text_color    = data_i[31:0];
        CFG_LINE_PITCH:    cfg_d.line_pitch    = data_i[7:0];
        CFG_GLYPH_SPACING: cfg_d.glyph_spacing = data_i[7:0];
        CFG_SPACE_WIDTH:   cfg_d.space_width   = data_i[7:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q               <= '0;
      cfg_q.line_pitch    <= 8'd16;
      cfg_q.space_width   <= 8'd8;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* rtl/tgp_ctrl.sv */
// Sequencing state machine for the text glyph placement block.
module tgp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tgp_pkg::sts_t sts_i,
  output tgp_pkg::cmd_t cmd_o
);
  import tgp_pkg::*;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.item_tab) begin
            state_d = ST_DIV;
          end else if (sts_i.item_glyph) begin
            state_d = ST_PLACE;
          end
        end
      end
      ST_PLACE: begin
        if (sts_i.out_free) begin
          cmd_o.place = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_TAB;
        end
      end
      ST_TAB: begin
        cmd_o.tab_finish = 1'b1;
        state_d          = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/tgp_datapath.sv */
// Pen state, tab remainder divider and result register of the glyph placement block.
module tgp_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tgp_pkg::cfg_t                  cfg_i,
  input  tgp_pkg::cmd_t                  cmd_i,
  output tgp_pkg::sts_t                  sts_o,
  input  logic [tgp_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic [tgp_pkg::IN_USER_W-1:0]  in_user_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tgp_pkg::OUT_DATA_W-1:0] out_data_o
);
  import tgp_pkg::*;

  // Request fields
  logic              in_new_text;
  logic              in_present;
  logic [7:0]        in_code;
  logic [7:0]        in_adv;
  logic signed [7:0] in_bx;
  logic signed [7:0] in_by;

  assign in_new_text = in_user_i[0];
  assign in_present  = in_user_i[1];
  assign in_code     = in_data_i[7:0];
  assign in_adv      = in_data_i[15:8];
  assign in_bx       = in_data_i[23:16];
  assign in_by       = in_data_i[31:24];

  // Pen and item registers
  coord_t            pen_x_q, pen_x_d;
  coord_t            pen_y_q, pen_y_d;
  logic [7:0]        code_q;
  logic [7:0]        adv_q;
  logic signed [7:0] bx_q;
  logic signed [7:0] by_q;

  // Divider registers
  logic [COORD_BITS-1:0] mag_q, mag_d;
  logic [TAB_W-1:0]      rem_q, rem_d;
  logic                  neg_q, neg_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  // Result register
  logic                out_valid_q, out_valid_d;
  logic [7:0]          o_code_q;
  logic [SCREEN_W-1:0] o_sx_q;
  logic [SCREEN_W-1:0] o_sy_q;
  logic [31:0]         o_color_q;

  // Decode of the offered item
  logic is_nl, is_cr, is_tab, is_glyph;
  assign is_nl    = (in_code == CH_NEWLINE);
  assign is_cr    = (in_code == CH_RETURN);
  assign is_tab   = (in_code == CH_TAB);
  assign is_glyph = in_present && !is_nl && !is_cr && !is_tab;

  // Origin, pen after the new-text flag, next line position
  coord_t ox, oy, px0, py0, py_step;
  wide_t  off_x;
  logic   wrap_hit;
  assign ox      = sat_coord(wide_t'(cfg_i.origin_x));
  assign oy      = sat_coord(wide_t'(cfg_i.origin_y));
  assign px0     = in_new_text ? ox : pen_x_q;
  assign py0     = in_new_text ? oy : pen_y_q;
  assign py_step = sat_coord(wide_t'(py0) + wide_t'(cfg_i.line_pitch));
  assign off_x   = wide_t'(px0) - wide_t'(ox);

  // Word wrap test on the incoming glyph
  assign wrap_hit = cfg_i.wrap_enable && (cfg_i.wrap_width != '0) &&
                    ((off_x + wide_t'(in_adv)) > wide_t'(cfg_i.wrap_width)) &&
                    (px0 > ox);

  // Tab width, zero space width taken as the default
  logic [SPACE_W-1:0] sw_eff;
  logic [TAB_W-1:0]   tab_w;
  assign sw_eff = (cfg_i.space_width == '0) ? DEFAULT_SPACE : cfg_i.space_width;
  assign tab_w  = TAB_W'(sw_eff * TAB_SPACES);

  // One restoring step of |offset| mod tab width
  logic [TAB_W:0] part;
  assign part = {rem_q, mag_q[COORD_BITS-1]};

  // Tab target: pen - signed remainder + tab width
  wide_t rem_s;
  assign rem_s = neg_q ? -wide_t'(rem_q) : wide_t'(rem_q);

  // Placement sums
  coord_t sx, sy, adv_x;
  wide_t  sx_w, sy_w;
  assign sx    = sat_coord(wide_t'(pen_x_q) + wide_t'(bx_q));
  assign sy    = sat_coord(wide_t'(pen_y_q) + wide_t'(by_q));
  assign sx_w  = wide_t'(sx);
  assign sy_w  = wide_t'(sy);
  assign adv_x = sat_coord(wide_t'(pen_x_q) + wide_t'(adv_q) + wide_t'(cfg_i.glyph_spacing));

  // Status
  assign sts_o.item_tab   = is_tab;
  assign sts_o.item_glyph = is_glyph;
  assign sts_o.div_last   = (cnt_q == CNT_W'(DIV_STEPS - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Pen and divider next state
  always_comb begin
    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    if (cmd_i.accept) begin
      pen_x_d = px0;
      pen_y_d = py0;
      if (is_nl) begin
        pen_x_d = ox;
        pen_y_d = py_step;
      end else if (is_cr) begin
        pen_x_d = ox;
      end else if (is_tab) begin
        neg_d = off_x[WIDE_W-1];
        mag_d = off_x[WIDE_W-1] ? COORD_BITS'(-off_x) : COORD_BITS'(off_x);
        rem_d = '0;
        cnt_d = '0;
      end else if (is_glyph && wrap_hit) begin
        pen_x_d = ox;
        pen_y_d = py_step;
      end
    end
    if (cmd_i.div_step) begin
      rem_d = (part >= {1'b0, tab_w}) ? TAB_W'(part - {1'b0, tab_w}) : TAB_W'(part);
      mag_d = mag_q << 1;
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (cmd_i.tab_finish) begin
      pen_x_d = sat_coord(wide_t'(pen_x_q) - rem_s + wide_t'(tab_w));
    end
    if (cmd_i.place) begin
      pen_x_d = adv_x;
    end
  end

  // Result valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.place) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pen_x_q     <= pen_x_d;
      pen_y_q     <= pen_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    if (cmd_i.accept) begin
      code_q <= in_code;
      adv_q  <= in_adv;
      bx_q   <= in_bx;
      by_q   <= in_by;
    end
    if (cmd_i.place) begin
      o_code_q  <= code_q;
      o_sx_q    <= sx_w[SCREEN_W-1:0];
      o_sy_q    <= sy_w[SCREEN_W-1:0];
      o_color_q <= cfg_i.text_color;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {o_color_q, o_sy_q, o_sx_q, o_code_q};

endmodule

/* rtl/text_glyph_placement_top.sv */
// Top level of the text glyph placement block.
//
//  Channel   Direction  Handshake                      Request contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  one character with its glyph metrics
//  m_axis    out        m_axis_tvalid / m_axis_tready  one placed glyph
//  cfg       in         cfg_valid_i / cfg_ready_o      register index and write data
//
// Newline, return, missing glyphs and plain flag-only characters complete when accepted.
// A present glyph goes through accept, then placement into the output register.
// A tab goes through accept, 16 radix-2 steps of the remainder divider, then a final add.
// A placed glyph waits in the output register while m_axis stalls; further
// characters are still accepted until the next glyph needs that register.
// Reset clears the pen to (0, 0) and loads the register defaults; no clearing pass.
module text_glyph_placement_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // s_axis
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // char_code[7:0], glyph_advance[15:8], glyph_bearing_x[23:16], glyph_bearing_y[31:24]
  input  logic [tgp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // new_text[0], glyph_present[1]
  input  logic [tgp_pkg::IN_USER_W-1:0]  s_axis_tuser,
  // m_axis
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // glyph_code[7:0], pos_x[23:8], pos_y[39:24], glyph_color[71:40]
  output logic [tgp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tgp_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [tgp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tgp_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  tgp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cfg_valid_i),
    .ready_o (cfg_ready_o),
    .addr_i  (cfg_addr_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  tgp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tgp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* rtl/tgp_checker.sv */
// Port-level checks for the text glyph placement block, bound to the top level.
module tgp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [tgp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tgp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import tgp_pkg::*;

  // A new result only appears after a placement cycle, when input was held off
  a_result_after_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a placement cycle");

  // A tab occupies the divider, so the next request is held off
  a_tab_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[7:0] == CH_TAB) |=> !s_axis_tready)
    else $error("request taken during tab division");

  // A newline completes in its accept cycle
  a_newline_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[7:0] == CH_NEWLINE) |=> s_axis_tready)
    else $error("newline held the input channel");

  // A stalled result is held unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result dropped or changed");

endmodule

bind text_glyph_placement_top tgp_checker u_tgp_checker (.*);
